FILE: design/cbef_pkg.sv
`default_nettype none

package cbef_pkg;

    // Counts of nodes and clusters are held in this width (covers up to 511).
    localparam int CNT_W = 9;

    localparam int MAX_NODES_DEF    = 64;
    localparam int MAX_CLUSTERS_DEF = 64;
    localparam int WEIGHT_BITS_DEF  = 16;

    localparam int COUNT_RST = 64;

    localparam int NODE_W   = 6;
    localparam int EW_W     = 16;
    localparam int TOTAL_W  = 16;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    // Configuration register indexes
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_NODE_COUNT    = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_CLUSTER_COUNT = 1'd1;
    localparam int CFG_W = 7;

    // Request codes
    localparam logic [1:0] REQ_SET  = 2'd0;
    localparam logic [1:0] REQ_ADD  = 2'd1;
    localparam logic [1:0] REQ_TEST = 2'd2;

    // Request class after range checks
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_SET  = 2'd1;
    localparam logic [1:0] KIND_ADD  = 2'd2;
    localparam logic [1:0] KIND_TEST = 2'd3;

    // Datapath actions
    localparam int ACT_W = 4;
    localparam logic [ACT_W-1:0] ACT_NOP    = 4'd0;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 4'd1;
    localparam logic [ACT_W-1:0] ACT_IDLE   = 4'd2;
    localparam logic [ACT_W-1:0] ACT_WR_CLU = 4'd3;
    localparam logic [ACT_W-1:0] ACT_WR_WT  = 4'd4;
    localparam logic [ACT_W-1:0] ACT_RD_CV  = 4'd5;
    localparam logic [ACT_W-1:0] ACT_SETUP  = 4'd6;
    localparam logic [ACT_W-1:0] ACT_SCAN   = 4'd7;
    localparam logic [ACT_W-1:0] ACT_DRAIN  = 4'd8;
    localparam logic [ACT_W-1:0] ACT_REDUCE = 4'd9;
    localparam logic [ACT_W-1:0] ACT_EMIT   = 4'd10;

    // Branch kinds
    localparam int BR_W = 3;
    localparam logic [BR_W-1:0] BR_NEXT  = 3'd0;
    localparam logic [BR_W-1:0] BR_JUMP  = 3'd1;
    localparam logic [BR_W-1:0] BR_CLEAR = 3'd2;
    localparam logic [BR_W-1:0] BR_IDLE  = 3'd3;
    localparam logic [BR_W-1:0] BR_LOOP  = 3'd4;
    localparam logic [BR_W-1:0] BR_EMIT  = 3'd5;

    // Program steps
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] ST_CLEAR  = 4'd0;
    localparam logic [STEP_W-1:0] ST_IDLE   = 4'd1;
    localparam logic [STEP_W-1:0] ST_WRCLU  = 4'd2;
    localparam logic [STEP_W-1:0] ST_WRWT   = 4'd3;
    localparam logic [STEP_W-1:0] ST_RDCV   = 4'd4;
    localparam logic [STEP_W-1:0] ST_SETUP  = 4'd5;
    localparam logic [STEP_W-1:0] ST_SCAN   = 4'd6;
    localparam logic [STEP_W-1:0] ST_DRAIN  = 4'd7;
    localparam logic [STEP_W-1:0] ST_REDUCE = 4'd8;
    localparam logic [STEP_W-1:0] ST_EMIT   = 4'd9;

    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [BR_W-1:0]   br;
        logic [STEP_W-1:0] tgt;
    } uword_t;

    typedef struct packed {
        logic        in_fire;
        logic [1:0]  kind;
        logic        clr_more;
        logic        scan_more;
    } stat_t;

    // Last field in the lowest bits
    typedef struct packed {
        logic [NODE_W-1:0] cluster_id;
        logic [EW_W-1:0]   edge_weight;
        logic [NODE_W-1:0] node_b;
        logic [NODE_W-1:0] node_a;
        logic [1:0]        req_type;
    } req_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] eliminated_total;
        logic               eliminate;
    } res_t;

    function automatic uword_t ucode(input logic [STEP_W-1:0] step);
        uword_t w;
        case (step)
            ST_CLEAR:  w = '{ACT_CLEAR,  BR_CLEAR, ST_CLEAR};
            ST_IDLE:   w = '{ACT_IDLE,   BR_IDLE,  ST_IDLE};
            ST_WRCLU:  w = '{ACT_WR_CLU, BR_JUMP,  ST_EMIT};
            ST_WRWT:   w = '{ACT_WR_WT,  BR_JUMP,  ST_EMIT};
            ST_RDCV:   w = '{ACT_RD_CV,  BR_NEXT,  ST_IDLE};
            ST_SETUP:  w = '{ACT_SETUP,  BR_NEXT,  ST_IDLE};
            ST_SCAN:   w = '{ACT_SCAN,   BR_LOOP,  ST_SCAN};
            ST_DRAIN:  w = '{ACT_DRAIN,  BR_NEXT,  ST_IDLE};
            ST_REDUCE: w = '{ACT_REDUCE, BR_NEXT,  ST_IDLE};
            ST_EMIT:   w = '{ACT_EMIT,   BR_EMIT,  ST_IDLE};
            default:   w = '{ACT_NOP,    BR_JUMP,  ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: design/cbef_wstore.sv
`default_nettype none

// Weight store: one write port, two registered read ports.
// Entry is {infinite flag, weight}.
module cbef_wstore #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 17
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic [AW-1:0] rd_addr0,
    input  wire logic [AW-1:0] rd_addr1,
    output logic      [DW-1:0] rd_data0,
    output logic      [DW-1:0] rd_data1
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data0 <= mem[rd_addr0];
        rd_data1 <= mem[rd_addr1];
    end

endmodule

`default_nettype wire

FILE: design/cbef_seq.sv
`default_nettype none

// Micro-sequencer: step counter over the control ROM in the package.
module cbef_seq (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire cbef_pkg::stat_t            stat,
    input  wire logic                       out_busy,
    output logic [cbef_pkg::ACT_W-1:0]      act
);

    logic [cbef_pkg::STEP_W-1:0] step_reg;
    logic [cbef_pkg::STEP_W-1:0] step_next;
    logic [cbef_pkg::STEP_W-1:0] disp;
    cbef_pkg::uword_t            uw;

    assign uw  = cbef_pkg::ucode(step_reg);
    assign act = uw.act;

    always_comb
    begin
        case (stat.kind)
            cbef_pkg::KIND_SET:  disp = cbef_pkg::ST_WRCLU;
            cbef_pkg::KIND_ADD:  disp = cbef_pkg::ST_WRWT;
            cbef_pkg::KIND_TEST: disp = cbef_pkg::ST_RDCV;
            default:             disp = cbef_pkg::ST_EMIT;
        endcase
    end

    always_comb
    begin
        case (uw.br)
            cbef_pkg::BR_NEXT:  step_next = step_reg + 1'b1;
            cbef_pkg::BR_JUMP:  step_next = uw.tgt;
            cbef_pkg::BR_CLEAR: step_next = stat.clr_more ? uw.tgt : step_reg + 1'b1;
            cbef_pkg::BR_IDLE:  step_next = stat.in_fire ? disp : step_reg;
            cbef_pkg::BR_LOOP:  step_next = stat.scan_more ? uw.tgt : step_reg + 1'b1;
            cbef_pkg::BR_EMIT:  step_next = out_busy ? step_reg : uw.tgt;
            default:            step_next = cbef_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= cbef_pkg::ST_CLEAR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/cbef_dpath.sv
`default_nettype none

// Datapath: request latch, node cluster memory, member scan with per-cluster
// fail bits, reduction and elimination counter.
module cbef_dpath #(
    parameter int MAX_NODES    = cbef_pkg::MAX_NODES_DEF,
    parameter int MAX_CLUSTERS = cbef_pkg::MAX_CLUSTERS_DEF,
    parameter int WEIGHT_BITS  = cbef_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [cbef_pkg::ACT_W-1:0]    act,
    input  wire logic                          in_fire,
    input  wire cbef_pkg::req_t                in_req,
    input  wire logic [cbef_pkg::CNT_W-1:0]    node_n,
    input  wire logic [cbef_pkg::CNT_W-1:0]    clu_n,
    output cbef_pkg::stat_t                    stat,
    output cbef_pkg::res_t                     res
);

    localparam int NB    = $clog2(MAX_NODES);
    localparam int DEPTH = MAX_NODES * MAX_NODES;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = WEIGHT_BITS + 1;
    localparam int CW    = cbef_pkg::CNT_W;

    // request latch
    logic [cbef_pkg::NODE_W-1:0]  a_reg;
    logic [cbef_pkg::NODE_W-1:0]  b_reg;
    logic [cbef_pkg::NODE_W-1:0]  cid_reg;
    logic [WEIGHT_BITS-1:0]       w_reg;
    logic [WEIGHT_BITS-1:0]       w_in;
    logic                         w_over;
    logic [NB-1:0]                a_idx;
    logic [NB-1:0]                b_idx;
    logic [NB-1:0]                in_a_idx;

    // scan state
    logic [cbef_pkg::NODE_W-1:0]  cu_reg;
    logic [cbef_pkg::NODE_W-1:0]  cv_reg;
    logic [CW-1:0]                x_reg;
    logic [CW-1:0]                x_next;
    logic [NB-1:0]                xp_reg;
    logic                         pv_reg;
    logic                         pv_next;
    logic [MAX_CLUSTERS-1:0]      fail_reg;
    logic [MAX_CLUSTERS-1:0]      fail_next;
    logic [MAX_CLUSTERS-1:0]      ok_vec;
    logic                         ok_any;
    logic                         elim_reg;
    logic [cbef_pkg::TOTAL_W-1:0] count_reg;
    logic [cbef_pkg::TOTAL_W-1:0] count_next;
    logic [AW-1:0]                clr_addr_reg;

    // cluster memory
    logic [cbef_pkg::NODE_W-1:0]  clu_mem [MAX_NODES];
    logic [cbef_pkg::NODE_W-1:0]  clu_rd;
    logic [NB-1:0]                clu_raddr;

    // weight store ports
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [SW-1:0]                wr_data;
    logic [AW-1:0]                rd_addr0;
    logic [AW-1:0]                rd_addr1;
    logic [SW-1:0]                wu_rd;
    logic [SW-1:0]                wv_rd;
    logic [SW-1:0]                wu;
    logic [SW-1:0]                wv;
    logic                         eval;
    logic                         bad;
    logic                         a_ok;
    logic                         b_ok;

    function automatic logic [AW-1:0] waddr(input logic [NB-1:0] p, input logic [NB-1:0] q);
        logic [NB-1:0] lo;
        logic [NB-1:0] hi;
        lo = (p < q) ? p : q;
        hi = (p < q) ? q : p;
        return AW'(lo) * AW'(MAX_NODES) + AW'(hi);
    endfunction

    // input decode
    assign w_over = (WEIGHT_BITS < cbef_pkg::EW_W)
                 && ((32'(in_req.edge_weight) >> WEIGHT_BITS) != 32'd0);
    assign w_in   = w_over ? '1 : WEIGHT_BITS'(in_req.edge_weight);
    assign a_ok   = CW'(in_req.node_a) < node_n;
    assign b_ok   = CW'(in_req.node_b) < node_n;

    always_comb
    begin
        stat.in_fire   = in_fire;
        stat.clr_more  = clr_addr_reg != AW'(DEPTH - 1);
        stat.scan_more = (x_reg + CW'(1)) < node_n;
        case (in_req.req_type)
            cbef_pkg::REQ_SET:
                stat.kind = a_ok ? cbef_pkg::KIND_SET : cbef_pkg::KIND_NONE;
            cbef_pkg::REQ_ADD:
                stat.kind = (a_ok && b_ok && (in_req.node_a != in_req.node_b))
                          ? cbef_pkg::KIND_ADD : cbef_pkg::KIND_NONE;
            cbef_pkg::REQ_TEST:
                stat.kind = (a_ok && b_ok) ? cbef_pkg::KIND_TEST : cbef_pkg::KIND_NONE;
            default:
                stat.kind = cbef_pkg::KIND_NONE;
        endcase
    end

    assign a_idx    = NB'(a_reg);
    assign b_idx    = NB'(b_reg);
    assign in_a_idx = NB'(in_req.node_a);

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_reg   <= in_req.node_a;
            b_reg   <= in_req.node_b;
            cid_reg <= in_req.cluster_id;
            w_reg   <= w_in;
        end
    end

    // cluster memory: read u while idle, v next, then each scanned node
    always_comb
    begin
        case (act)
            cbef_pkg::ACT_IDLE:  clu_raddr = in_a_idx;
            cbef_pkg::ACT_RD_CV: clu_raddr = b_idx;
            default:             clu_raddr = x_reg[NB-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (act == cbef_pkg::ACT_WR_CLU)
        begin
            clu_mem[a_idx] <= cid_reg;
        end
        clu_rd <= clu_mem[clu_raddr];
    end

    // weight store; only the pair with the lower node first is kept
    assign wr_en    = (act == cbef_pkg::ACT_WR_WT) || (act == cbef_pkg::ACT_CLEAR);
    assign wr_addr  = (act == cbef_pkg::ACT_CLEAR) ? clr_addr_reg : waddr(a_idx, b_idx);
    assign wr_data  = (act == cbef_pkg::ACT_CLEAR) ? {1'b1, {WEIGHT_BITS{1'b0}}}
                                                   : {1'b0, w_reg};
    assign rd_addr0 = waddr(a_idx, x_reg[NB-1:0]);
    assign rd_addr1 = waddr(b_idx, x_reg[NB-1:0]);

    cbef_wstore #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (SW)
    ) u_wstore (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_addr0 (rd_addr0),
        .rd_addr1 (rd_addr1),
        .rd_data0 (wu_rd),
        .rd_data1 (wv_rd)
    );

    // evaluate the node read in the previous cycle; diagonal reads zero
    assign wu   = (xp_reg == a_idx) ? '0 : wu_rd;
    assign wv   = (xp_reg == b_idx) ? '0 : wv_rd;
    assign eval = ((act == cbef_pkg::ACT_SCAN) || (act == cbef_pkg::ACT_DRAIN)) && pv_reg;
    assign bad  = wu[WEIGHT_BITS] || wv[WEIGHT_BITS]
               || (wu[WEIGHT_BITS-1:0] > w_reg) || (wv[WEIGHT_BITS-1:0] > w_reg);

    always_comb
    begin
        for (int c = 0; c < MAX_CLUSTERS; c++)
        begin
            if (act == cbef_pkg::ACT_SETUP)
            begin
                fail_next[c] = 1'b0;
            end
            else
            begin
                fail_next[c] = fail_reg[c] || (eval && bad && (CW'(clu_rd) == CW'(c)));
            end
            ok_vec[c] = !fail_reg[c] && (CW'(c) < clu_n)
                     && (CW'(cu_reg) != CW'(c)) && (CW'(cv_reg) != CW'(c));
        end
    end

    assign ok_any = |ok_vec;

    always_comb
    begin
        x_next     = x_reg;
        pv_next    = pv_reg;
        count_next = count_reg;
        case (act)
            cbef_pkg::ACT_SETUP:
            begin
                x_next  = '0;
                pv_next = 1'b0;
            end
            cbef_pkg::ACT_SCAN:
            begin
                x_next  = x_reg + CW'(1);
                pv_next = 1'b1;
            end
            cbef_pkg::ACT_REDUCE:
            begin
                if (ok_any && (count_reg != '1))
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        fail_reg <= fail_next;
        if (act == cbef_pkg::ACT_RD_CV)
        begin
            cu_reg <= clu_rd;
        end
        if (act == cbef_pkg::ACT_SETUP)
        begin
            cv_reg <= clu_rd;
        end
        if (act == cbef_pkg::ACT_SCAN)
        begin
            xp_reg <= x_reg[NB-1:0];
        end
        if (in_fire)
        begin
            elim_reg <= 1'b0;
        end
        else if (act == cbef_pkg::ACT_REDUCE)
        begin
            elim_reg <= ok_any;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg        <= '0;
            pv_reg       <= 1'b0;
            count_reg    <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            x_reg     <= x_next;
            pv_reg    <= pv_next;
            count_reg <= count_next;
            if (act == cbef_pkg::ACT_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    assign res.eliminate        = elim_reg;
    assign res.eliminated_total = count_reg;

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (act == cbef_pkg::ACT_SCAN) |-> (x_reg < node_n))
        else $error("scan index past node count");

    a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
        (act == cbef_pkg::ACT_REDUCE) |-> pv_reg)
        else $error("reduce without any scanned node");

    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg >= $past(count_reg)))
        else $error("elimination count went down");

    a_elim_count: assert property (@(posedge clk) disable iff (!rst_n)
        ((act == cbef_pkg::ACT_REDUCE) && ok_any) |=> (count_reg != '0) && elim_reg)
        else $error("elimination not counted");

endmodule

`default_nettype wire

FILE: design/cluster_bottleneck_edge_filter.sv
`default_nettype none

// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    s_tdata: req_type, node_a, node_b, edge_weight, cluster_id
// m_*       out  m_tvalid/m_tready    m_tdata: eliminate, eliminated_total
// cfg_*     in   cfg_wen              cfg_idx, cfg_wdata (node_count, cluster_count)
//
// Set and add requests go through a write step to the emit step; a test reads both
// clusters, scans one node per cycle through the two read ports of the weight store,
// then reduces and emits. After reset a clearing pass writes every weight entry to
// infinite, all MAX_NODES * MAX_NODES entries (4096 by default), s_tready low meanwhile.
// One output word is held in a register; a stalled m_tready holds the sequencer
// at its emit step, and s_tready is high only at the idle step.
module cluster_bottleneck_edge_filter #(
    parameter int MAX_NODES    = cbef_pkg::MAX_NODES_DEF,
    parameter int MAX_CLUSTERS = cbef_pkg::MAX_CLUSTERS_DEF,
    parameter int WEIGHT_BITS  = cbef_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [1:0] req_type, [7:2] node_a, [13:8] node_b, [29:14] edge_weight, [35:30] cluster_id
    input  wire logic [cbef_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [0] eliminate, [16:1] eliminated_total
    output logic      [cbef_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  wire logic                                cfg_wen,
    input  wire logic [cbef_pkg::REG_IDX_W-1:0]      cfg_idx,
    input  wire logic [cbef_pkg::CFG_W-1:0]          cfg_wdata
);

    localparam int CW = cbef_pkg::CNT_W;
    localparam int REQ_W = $bits(cbef_pkg::req_t);
    localparam int RES_W = $bits(cbef_pkg::res_t);
    localparam logic [CW-1:0] NODE_RST = (cbef_pkg::COUNT_RST > MAX_NODES)
                                       ? CW'(MAX_NODES) : CW'(cbef_pkg::COUNT_RST);
    localparam logic [CW-1:0] CLU_RST  = (cbef_pkg::COUNT_RST > MAX_CLUSTERS)
                                       ? CW'(MAX_CLUSTERS) : CW'(cbef_pkg::COUNT_RST);

    logic [cbef_pkg::ACT_W-1:0]     act;
    cbef_pkg::stat_t                stat;
    cbef_pkg::req_t                 in_req;
    cbef_pkg::res_t                 res;
    logic                           in_fire;
    logic                           out_busy;
    logic                           out_load;

    logic [CW-1:0]                  node_n_reg;
    logic [CW-1:0]                  clu_n_reg;
    logic [CW-1:0]                  cfg_node;
    logic [CW-1:0]                  cfg_clu;

    logic                           m_tvalid_reg;
    logic                           m_tvalid_next;
    logic [cbef_pkg::OUT_TDATA_W-1:0] m_tdata_reg;

    assign in_req   = cbef_pkg::req_t'(s_tdata[REQ_W-1:0]);
    assign s_tready = (act == cbef_pkg::ACT_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    // configuration: counts are capped at the sizes built in
    assign cfg_node = (CW'(cfg_wdata) > CW'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(cfg_wdata);
    assign cfg_clu  = (CW'(cfg_wdata) > CW'(MAX_CLUSTERS)) ? CW'(MAX_CLUSTERS)
                                                           : CW'(cfg_wdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_n_reg <= NODE_RST;
            clu_n_reg  <= CLU_RST;
        end
        else if (cfg_wen)
        begin
            case (cfg_idx)
                cbef_pkg::REG_NODE_COUNT:    node_n_reg <= cfg_node;
                cbef_pkg::REG_CLUSTER_COUNT: clu_n_reg  <= cfg_clu;
                default:
                begin
                end
            endcase
        end
    end

    cbef_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (stat),
        .out_busy (out_busy),
        .act      (act)
    );

    cbef_dpath #(
        .MAX_NODES    (MAX_NODES),
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .act     (act),
        .in_fire (in_fire),
        .in_req  (in_req),
        .node_n  (node_n_reg),
        .clu_n   (clu_n_reg),
        .stat    (stat),
        .res     (res)
    );

    // output register; a word being taken this cycle frees it
    assign out_busy = m_tvalid_reg && !m_tready;
    assign out_load = (act == cbef_pkg::ACT_EMIT) && !out_busy;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= {{(cbef_pkg::OUT_TDATA_W - RES_W){1'b0}}, res};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
